/* rtl/crcub_pkg.sv */
package crcub_pkg;

    localparam int DataWidth = 16;
    localparam int AlgWidth  = 3;

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } acc_t;

    typedef enum logic [1:0] {
        REG_CTRL   = 2'd0,
        REG_DATA   = 2'd1,
        REG_RESULT = 2'd2
    } reg_sel_t;

    typedef enum logic [AlgWidth-1:0] {
        ALG_IDLE_LO    = 3'd0,
        ALG_CRC8_LSB   = 3'd1,
        ALG_CRC16_LSB  = 3'd2,
        ALG_CCITT_LSB  = 3'd3,
        ALG_IDLE_HI    = 3'd4,
        ALG_CRC8_MSB   = 3'd5,
        ALG_CRC16_MSB  = 3'd6,
        ALG_CCITT_MSB  = 3'd7
    } alg_t;

    localparam logic [7:0]  POLY8_MSB  = 8'h07;
    localparam logic [7:0]  POLY8_LSB  = 8'hE0;
    localparam logic [15:0] POLY16_MSB = 16'h8005;
    localparam logic [15:0] POLY16_LSB = 16'hA001;
    localparam logic [15:0] POLYCC_MSB = 16'h1021;
    localparam logic [15:0] POLYCC_LSB = 16'h8408;

    localparam int CtrlClearBit = 7;

    typedef struct packed {
        acc_t                 mode;
        reg_sel_t             reg_select;
        logic [DataWidth-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [AlgWidth-1:0]  alg;
        logic [DataWidth-1:0] crc;
    } state_t;

endpackage

/* rtl/crcub_crc_byte.sv */
module crcub_crc_byte (
    input  logic [crcub_pkg::AlgWidth-1:0]  alg,
    input  logic [crcub_pkg::DataWidth-1:0] crc,
    input  logic [7:0]                      data,
    output logic [crcub_pkg::DataWidth-1:0] crc_next
);
    import crcub_pkg::*;

    logic [15:0] c16;
    logic [7:0]  c8;
    logic [15:0] poly16;

    always_comb begin
        c16      = '0;
        c8       = '0;
        poly16   = '0;
        crc_next = crc;
        unique case (alg_t'(alg))
            ALG_CRC8_LSB, ALG_CRC16_LSB, ALG_CCITT_LSB: begin
                if (alg_t'(alg) == ALG_CRC8_LSB) begin
                    c16    = {8'h00, crc[7:0] ^ data};
                    poly16 = {8'h00, POLY8_LSB};
                end else begin
                    c16    = crc ^ {8'h00, data};
                    poly16 = (alg_t'(alg) == ALG_CRC16_LSB) ? POLY16_LSB : POLYCC_LSB;
                end
                for (int i = 0; i < 8; i++) begin
                    c16 = c16[0] ? ((c16 >> 1) ^ poly16) : (c16 >> 1);
                end
                crc_next = c16;
            end
            ALG_CRC8_MSB: begin
                c8 = crc[7:0] ^ data;
                for (int i = 0; i < 8; i++) begin
                    c8 = c8[7] ? ((c8 << 1) ^ POLY8_MSB) : (c8 << 1);
                end
                crc_next = {8'h00, c8};
            end
            ALG_CRC16_MSB, ALG_CCITT_MSB: begin
                c16    = crc ^ {data, 8'h00};
                poly16 = (alg_t'(alg) == ALG_CRC16_MSB) ? POLY16_MSB : POLYCC_MSB;
                for (int i = 0; i < 8; i++) begin
                    c16 = c16[15] ? ((c16 << 1) ^ poly16) : (c16 << 1);
                end
                crc_next = c16;
            end
            default: begin
                crc_next = crc;
            end
        endcase
    end

endmodule

/* rtl/crcub_regs.sv */
module crcub_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_fire,
    input  crcub_pkg::req_t                 req,
    output logic [crcub_pkg::DataWidth-1:0] read_data,
    output crcub_pkg::state_t               state
);
    import crcub_pkg::*;

    logic [AlgWidth-1:0]  alg_reg;
    logic [AlgWidth-1:0]  alg_next;
    logic [DataWidth-1:0] crc_reg;
    logic [DataWidth-1:0] crc_next;
    logic [DataWidth-1:0] crc_fed;

    crcub_crc_byte u_crc_byte (
        .alg      (alg_reg),
        .crc      (crc_reg),
        .data     (req.write_data[7:0]),
        .crc_next (crc_fed)
    );

    always_comb begin
        alg_next  = alg_reg;
        crc_next  = crc_reg;
        read_data = '0;
        if (req.mode == ACC_WRITE) begin
            unique case (req.reg_select)
                REG_CTRL: begin
                    alg_next = req.write_data[AlgWidth-1:0];
                    if (req.write_data[CtrlClearBit]) begin
                        crc_next = '0;
                    end
                end
                REG_DATA:   crc_next = crc_fed;
                REG_RESULT: crc_next = req.write_data;
                default:    crc_next = crc_reg;
            endcase
        end else begin
            unique case (req.reg_select)
                REG_CTRL:   read_data = {{(DataWidth-AlgWidth){1'b0}}, alg_reg};
                REG_RESULT: read_data = crc_reg;
                default:    read_data = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg <= '0;
            crc_reg <= '0;
        end else if (req_fire) begin
            alg_reg <= alg_next;
            crc_reg <= crc_next;
        end
    end

    assign state = '{alg: alg_reg, crc: crc_reg};

endmodule

/* rtl/crc_unit_bus_registers_top.sv */
// CRC calculator with a small register bus carried on two streams.
// Each slave-side request is one register access: s_tuser gives the access
// kind (bit 0, 1 for a write) and the register offset (bits 2:1, 0 control,
// 1 data in, 2 result); s_tdata carries the write value.
// Every request returns exactly one response on the master side, whose
// m_tdata holds the value read, or zero for a write.
// A request is captured in the input register and is then executed
// against the control and result registers while its response is loaded
// into the output register, so a response leaves through the input and
// output registers in turn. The byte update of the CRC is combinational,
// and one request per cycle is accepted while m_tready stays high.
// When the receiver stalls, the response holds in the output register, the
// next request waits in the input register, and s_tready drops once both
// are full. Reset clears both registers' valid flags, the algorithm select
// and the result register.
module crc_unit_bus_registers_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_data
    input  logic [2:0]  s_tuser,   // mode, reg_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data
);
    import crcub_pkg::*;

    logic                 in_valid_reg;
    req_t                 in_req_reg;
    logic                 out_valid_reg;
    logic [DataWidth-1:0] out_data_reg;
    logic                 advance;
    logic [DataWidth-1:0] read_data;
    state_t               state;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg <= '{mode: acc_t'(s_tuser[0]), reg_select: reg_sel_t'(s_tuser[2:1]),
                            write_data: s_tdata};
        end
    end

    crcub_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_fire  (advance),
        .req       (in_req_reg),
        .read_data (read_data),
        .state     (state)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= read_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_req_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending request lost");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_req_reg.mode == ACC_WRITE && in_req_reg.reg_select == REG_CTRL
        && in_req_reg.write_data[CtrlClearBit] |=> state.crc == '0)
        else $error("control write with clear bit did not clear result");

    a_write_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_req_reg.mode == ACC_WRITE |=> m_tvalid && m_tdata == '0)
        else $error("write response not zero");

endmodule
